// ----- hw/rtl/step_to_unit_position_filter_assert.svh -----
// assertion macros for the step to unit position filter
`ifndef STEP_TO_UNIT_POSITION_FILTER_ASSERT_SVH
`define STEP_TO_UNIT_POSITION_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SUP_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SUP_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SUP_ASSERT_IMP(label, clk, rst, a, c)
`define SUP_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ----- hw/rtl/sup_pkg.sv -----
`default_nettype none
package sup_pkg;

  localparam int VOTE_DEPTH_DEF    = 16;
  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int ACC_W             = 15;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;

  localparam logic [ACC_W-1:0] ACC_MAX = 15'h7fff;

  localparam logic [2:0] ST_VALID      = 3'd0;
  localparam logic [2:0] ST_PATTERN    = 3'd1;
  localparam logic [2:0] ST_DEBOUNCED  = 3'd2;
  localparam logic [2:0] ST_RETREATED  = 3'd3;
  localparam logic [2:0] ST_ADVANCED   = 3'd4;
  localparam logic [2:0] ST_TOLERANCE  = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEPS_PER_UNIT  = 3'd0,
    REG_MAX_DEV         = 3'd1,
    REG_TOLERANCE_RATIO = 3'd2,
    REG_DEBOUNCE_COUNT  = 3'd3,
    REG_RUN_LIMIT       = 3'd4,
    REG_VOTE_WINDOW     = 3'd5,
    REG_MODE_FLAGS      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] steps_per_unit;
    logic [14:0] max_dev;
    logic [7:0]  tolerance_ratio;
    logic [7:0]  debounce_count;
    logic [15:0] run_limit;
    logic [4:0]  vote_window;
    logic [2:0]  mode_flags;
  } cfg_t;

  localparam logic [14:0] RST_STEPS_PER_UNIT  = 15'd200;
  localparam logic [14:0] RST_MAX_DEV         = 15'd10;
  localparam logic [7:0]  RST_TOLERANCE_RATIO = 8'd26;
  localparam logic [7:0]  RST_DEBOUNCE_COUNT  = 8'd3;
  localparam logic [15:0] RST_RUN_LIMIT       = 16'd1000;
  localparam logic [4:0]  RST_VOTE_WINDOW     = 5'd5;
  localparam logic [2:0]  RST_MODE_FLAGS      = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_FRONT, S_VOTE, S_SUM, S_SUMW, S_DINIT, S_DIV, S_CLAMP, S_STEP, S_ADV, S_WRITE
  } state_t;

  typedef struct packed {
    logic accept;
    logic front;
    logic vote_run;
    logic sum_run;
    logic div_init;
    logic div_run;
    logic clamp;
    logic step;
    logic adv;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic debounced;
    logic vote_done;
    logic sum_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sup_ctrl.sv -----
`default_nettype none
module sup_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sup_pkg::stat_t stat,
  output sup_pkg::cmd_t  cmd
);
  import sup_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FRONT;
        end
      end
      S_FRONT: begin
        cmd.front = 1'b1;
        state_next = stat.debounced ? S_WRITE : S_VOTE;
      end
      S_VOTE: begin
        cmd.vote_run = 1'b1;
        if (stat.vote_done) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_run = 1'b1;
        if (stat.sum_done) state_next = S_SUMW;
      end
      S_SUMW: state_next = S_DINIT;
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_done) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_next = S_ADV;
      end
      S_ADV: begin
        cmd.adv = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sup_dp.sv -----
`default_nettype none
module sup_dp #(
  parameter int VOTE_DEPTH    = sup_pkg::VOTE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = sup_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sup_pkg::cfg_t      cfg,
  input  logic               step_dir,
  input  sup_pkg::cmd_t      cmd,
  output sup_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [1:0]  pos_delta,
  output logic [14:0]        step_count
);
  import sup_pkg::*;

  localparam int VF_W  = $clog2(VOTE_DEPTH + 1);
  localparam int VI_W  = (VOTE_DEPTH > 1) ? $clog2(VOTE_DEPTH) : 1;
  localparam int HF_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int HA_W  = $clog2(HISTORY_DEPTH);
  localparam int SUM_W = ACC_W + HF_W;
  localparam int MAX_A = (VOTE_DEPTH > HISTORY_DEPTH) ? VOTE_DEPTH : HISTORY_DEPTH;
  localparam int MAX_I = (MAX_A > SUM_W) ? MAX_A : SUM_W;
  localparam int IDX_W = $clog2(MAX_I);

  logic                  dir_q, last_dir;
  logic [7:0]            dc;
  logic [15:0]           run;
  logic [VOTE_DEPTH-1:0] hist;
  logic [VF_W-1:0]       vf, fwd;
  logic [IDX_W-1:0]      idx;
  logic [ACC_W-1:0]      mem [HISTORY_DEPTH];
  logic [HA_W-1:0]       wr_ptr;
  logic [HF_W-1:0]       fill;
  logic [ACC_W-1:0]      rd_data;
  logic                  rd_ok;
  logic [SUM_W-1:0]      sum, quo;
  logic [HF_W:0]         rem;
  logic [ACC_W-1:0]      tol, thr, acc;
  logic [2:0]            res_status;
  logic [1:0]            res_change;

  logic                  same, pass, fdir, push, ge, adapt;
  logic [15:0]           run_inc, run_n, lo16, hi16;
  logic [7:0]            dc_inc;
  logic [VF_W-1:0]       win, vf_new;
  logic [VF_W:0]         vf_p1;
  logic [HF_W:0]         rem_sh;
  logic [SUM_W-1:0]      t_adp, t_base;
  logic [ACC_W-1:0]      push_val, dev;
  logic [22:0]           prod;

  assign same    = (dir_q == last_dir);
  assign run_inc = (run == 16'hffff) ? run : run + 16'd1;
  assign run_n   = same ? run_inc : 16'd1;
  assign dc_inc  = (dc == 8'hff) ? dc : dc + 8'd1;
  assign pass    = same || (dc_inc >= cfg.debounce_count);

  always_comb begin
    if (int'(cfg.vote_window) > VOTE_DEPTH) begin
      win = VF_W'(VOTE_DEPTH);
    end else if (cfg.vote_window == 5'd0) begin
      win = VF_W'(1);
    end else begin
      win = VF_W'(cfg.vote_window);
    end
  end
  assign vf_p1  = {1'b0, vf} + 1'b1;
  assign vf_new = (vf_p1 > {1'b0, win}) ? win : vf_p1[VF_W-1:0];

  always_comb begin
    if (!cfg.mode_flags[1] || (vf < win)) begin
      fdir = dir_q;
    end else begin
      fdir = (fwd > (vf >> 1)) ? 1'b0 : 1'b1;
    end
  end

  assign stat.debounced = !pass;
  assign stat.vote_done = (idx == IDX_W'(VOTE_DEPTH - 1));
  assign stat.sum_done  = (idx == IDX_W'(HISTORY_DEPTH - 1));
  assign stat.div_done  = (idx == IDX_W'(SUM_W - 1));
  assign stat.out_free  = !out_valid || out_ready;

  assign rem_sh = {rem[HF_W-1:0], quo[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, fill});
  assign prod   = 23'(cfg.steps_per_unit) * 23'(cfg.tolerance_ratio);

  assign lo16  = {1'b0, cfg.steps_per_unit} - {1'b0, tol};
  assign hi16  = {1'b0, cfg.steps_per_unit} + {1'b0, tol};
  assign adapt = cfg.mode_flags[2] && (fill >= HF_W'(2)) && (sum != '0);

  always_comb begin
    t_adp = quo;
    if (t_adp < SUM_W'(lo16)) t_adp = SUM_W'(lo16);
    if (t_adp > SUM_W'(hi16)) t_adp = SUM_W'(hi16);
    t_base = adapt ? t_adp : SUM_W'(cfg.steps_per_unit);
    if (t_base == '0) t_base = SUM_W'(1);
    if (t_base > SUM_W'(ACC_MAX)) t_base = SUM_W'(ACC_MAX);
  end

  assign dev = (acc > cfg.steps_per_unit) ? acc - cfg.steps_per_unit
                                          : cfg.steps_per_unit - acc;

  always_comb begin
    push = 1'b0;
    push_val = acc;
    if (cmd.step && fdir && (acc == '0)) begin
      push = 1'b1;
      push_val = thr;
    end else if (cmd.adv && (acc >= thr)) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_val;
    if (cmd.sum_run) rd_data <= mem[idx[HA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    rd_ok <= cmd.sum_run && (int'(idx) < int'(fill));
    if (cmd.accept) dir_q <= step_dir;
    if (cmd.front) begin
      fwd <= '0;
      idx <= '0;
      sum <= '0;
      res_change <= 2'b00;
      if (!pass) begin
        res_status <= ST_DEBOUNCED;
      end else if (cfg.mode_flags[0] && (run_n > cfg.run_limit)) begin
        res_status <= ST_PATTERN;
      end else begin
        res_status <= ST_VALID;
      end
    end
    if (cmd.vote_run) begin
      if ((int'(idx) < int'(vf)) && !hist[idx[VI_W-1:0]]) fwd <= fwd + 1'b1;
      idx <= stat.vote_done ? '0 : idx + 1'b1;
    end
    if (cmd.sum_run) idx <= stat.sum_done ? '0 : idx + 1'b1;
    if (rd_ok) sum <= sum + SUM_W'(rd_data);
    if (cmd.div_init) begin
      quo <= sum;
      rem <= '0;
      idx <= '0;
      tol <= prod[22:8];
    end
    if (cmd.div_run) begin
      rem <= ge ? rem_sh - {1'b0, fill} : rem_sh;
      quo <= {quo[SUM_W-2:0], ge};
      idx <= idx + 1'b1;
    end
    if (cmd.clamp) thr <= t_base[ACC_W-1:0];
    if (cmd.step && fdir && (acc == '0)) begin
      res_change <= 2'b11;
      res_status <= ST_RETREATED;
    end
    if (cmd.adv && (acc >= thr)) begin
      res_change <= 2'b01;
      if (dev > cfg.max_dev) begin
        res_status <= ST_TOLERANCE;
      end else if (res_status == ST_VALID || res_status == ST_PATTERN) begin
        res_status <= ST_ADVANCED;
      end
    end
    if (cmd.load_out) begin
      status <= res_status;
      pos_delta <= res_change;
      step_count <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_dir <= 1'b0;
      dc <= '0;
      run <= '0;
      hist <= '0;
      vf <= '0;
      fill <= '0;
      wr_ptr <= '0;
      acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.front) begin
        if (cfg.mode_flags[0]) run <= run_n;
        dc <= pass ? 8'd0 : dc_inc;
        if (pass && cfg.mode_flags[1]) begin
          hist <= VOTE_DEPTH'({hist, dir_q});
          vf <= vf_new;
        end
      end
      if (cmd.step) begin
        last_dir <= fdir;
        if (!fdir) begin
          if (acc != ACC_MAX) acc <= acc + 1'b1;
        end else if (acc != '0) begin
          acc <= acc - 1'b1;
        end else begin
          acc <= thr - 1'b1;
        end
      end
      if (cmd.adv && (acc >= thr)) acc <= '0;
      if (push) begin
        wr_ptr <= (wr_ptr == HA_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        if (fill != HF_W'(HISTORY_DEPTH)) fill <= fill + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/step_to_unit_position_filter.sv -----
// flow: a debounced step goes from acceptance straight to the output write; any other step
//   first runs the vote scan, history sum, mean divider, clamp, step and advance states
// throughput: a new step is taken only after the last is written out, paced by the vote
//   scan, the unit history scan over its memory port and the one bit a cycle mean divider
// reset: synchronous, clears all filter state and loads register defaults
`default_nettype none
`include "step_to_unit_position_filter_assert.svh"
module step_to_unit_position_filter #(
  parameter int VOTE_DEPTH    = sup_pkg::VOTE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = sup_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sup_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sup_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           step_dir,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic signed [1:0]              pos_delta,
  output logic [14:0]                    step_count
);
  import sup_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  out_adv, out_ret, out_still;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_unit  <= RST_STEPS_PER_UNIT;
      cfg.max_dev         <= RST_MAX_DEV;
      cfg.tolerance_ratio <= RST_TOLERANCE_RATIO;
      cfg.debounce_count  <= RST_DEBOUNCE_COUNT;
      cfg.run_limit       <= RST_RUN_LIMIT;
      cfg.vote_window     <= RST_VOTE_WINDOW;
      cfg.mode_flags      <= RST_MODE_FLAGS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEPS_PER_UNIT:  cfg.steps_per_unit  <= cfg_data[14:0];
        REG_MAX_DEV:         cfg.max_dev         <= cfg_data[14:0];
        REG_TOLERANCE_RATIO: cfg.tolerance_ratio <= cfg_data[7:0];
        REG_DEBOUNCE_COUNT:  cfg.debounce_count  <= cfg_data[7:0];
        REG_RUN_LIMIT:       cfg.run_limit       <= cfg_data;
        REG_VOTE_WINDOW:     cfg.vote_window     <= cfg_data[4:0];
        REG_MODE_FLAGS:      cfg.mode_flags      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  sup_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sup_dp #(
    .VOTE_DEPTH    (VOTE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step_dir    (step_dir),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pos_delta   (pos_delta),
    .step_count  (step_count)
  );

  assign out_adv   = out_valid && (status == ST_ADVANCED || status == ST_TOLERANCE);
  assign out_ret   = out_valid && (status == ST_RETREATED);
  assign out_still = out_valid &&
                     (status == ST_VALID || status == ST_PATTERN || status == ST_DEBOUNCED);

  `SUP_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `SUP_ASSERT_IMP(a_adv_change, clk, rst, out_adv, pos_delta == 2'sb01)
  `SUP_ASSERT_IMP(a_ret_change, clk, rst, out_ret, pos_delta == 2'sb11)
  `SUP_ASSERT_IMP(a_still_change, clk, rst, out_still, pos_delta == 2'sb00)

endmodule
`default_nettype wire
